// ----- rtl/layer_opacity_alpha_composite_top_defines.svh -----
// Assertion helpers for the compositing block.
`ifndef LAYER_OPACITY_ALPHA_COMPOSITE_TOP_DEFINES_SVH
`define LAYER_OPACITY_ALPHA_COMPOSITE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LOAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LOAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/loac_pkg.sv -----
`default_nettype none
package loac_pkg;

  localparam int unsigned STORE_DEPTH = 65536;
  localparam int unsigned IDX_W       = 16;

  localparam logic [6:0]  OPACITY_MAX = 7'd100;
  localparam logic [16:0] W_ONE       = 17'd65536;

  // w = 2*oa + floor((oa*3634 + 3187) / 6375), exact for oa <= 25500
  localparam logic [26:0] Z_MUL       = 27'd3634;
  localparam logic [26:0] Z_BIAS      = 27'd3187;
  localparam logic [27:0] W_RECIP     = 28'd172472413;  // ceil(2^40 / 6375)
  localparam int unsigned W_SHIFT     = 40;

  // floor(t / 100) for t < 2^16
  localparam logic [16:0] DIV100_RECIP = 17'd83887;     // ceil(2^23 / 100)
  localparam int unsigned DIV100_SHIFT = 23;

  localparam logic [32:0] ACC_ROUND   = 33'd3276800;
  localparam logic [15:0] COPY_ROUND  = 16'd50;
  localparam logic [7:0]  ALPHA_FULL  = 8'd255;

endpackage
`default_nettype wire

// ----- rtl/loac_if.sv -----
`default_nettype none
interface loac_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_index;
  logic        first_layer;
  logic [6:0]  opacity;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [7:0]  alpha_in;

  modport source (
    output valid, pixel_index, first_layer, opacity, red_in, green_in, blue_in, alpha_in,
    input  ready
  );
  modport sink (
    input  valid, pixel_index, first_layer, opacity, red_in, green_in, blue_in, alpha_in,
    output ready
  );
endinterface

interface loac_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_index_out;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [7:0]  alpha_out;

  modport source (
    output valid, pixel_index_out, red_out, green_out, blue_out, alpha_out,
    input  ready
  );
  modport sink (
    input  valid, pixel_index_out, red_out, green_out, blue_out, alpha_out,
    output ready
  );
endinterface
`default_nettype wire

// ----- rtl/layer_opacity_alpha_composite_top.sv -----
// A word accepted in ST_IDLE passes ST_RD, ST_WGT, ST_MIX, ST_ACC and ST_FIN, and is then
// registered to the output when it is free. A new word is taken only after the read-modify-write
// of the composite store (read, weight divide, mix, alpha sum, alpha divide, write) is done.
// A finished word waits in the output register while the next one is taken.
// Reset clears the sequencer and output valid; the store contents are undefined.
`default_nettype none
`include "layer_opacity_alpha_composite_top_defines.svh"
module layer_opacity_alpha_composite_top
  import loac_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  loac_in_if.sink        in_ch,
  loac_out_if.source     out_ch
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_WGT  = 3'd2;
  localparam logic [2:0] ST_MIX  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  function automatic logic [9:0] div100(input logic [15:0] t);
    logic [32:0] p;
    p = {17'd0, t} * {16'd0, DIV100_RECIP};
    return p[DIV100_SHIFT+9:DIV100_SHIFT];
  endfunction

  // c + w*(p-c)/65536, truncated
  function automatic logic [7:0] mix_channel(input logic [16:0] w, input logic [7:0] p,
                                             input logic [7:0] c);
    logic signed [26:0] w_s;
    logic signed [26:0] d_s;
    logic signed [26:0] sum;
    w_s = {10'd0, w};
    d_s = 27'(signed'({1'b0, p}) - signed'({1'b0, c}));
    sum = signed'({3'd0, c, 16'd0}) + w_s * d_s;
    return sum[23:16];
  endfunction

  logic [31:0] store_mem [STORE_DEPTH];
  logic [31:0] rd_data_r;

  logic [2:0]  state_r, state_nxt;
  logic [15:0] idx_r;
  logic        first_r;
  logic [7:0]  red_r, green_r, blue_r;
  logic [14:0] oa_r;
  logic [26:0] z_r;
  logic [16:0] w_r;
  logic [7:0]  mix_red_r, mix_green_r, mix_blue_r;
  logic [31:0] acc_prod_r;
  logic [15:0] t_r;

  logic        out_valid_r;
  logic [15:0] out_idx_r;
  logic [7:0]  out_red_r, out_green_r, out_blue_r, out_alpha_r;

  logic        accept;
  logic        out_free;
  logic        wr_en;
  logic [6:0]  op_sat;
  logic [7:0]  cur_alpha;
  logic [9:0]  q;
  logic [7:0]  alpha_fin;
  logic [54:0] w_prod;
  logic [32:0] acc_sum;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign wr_en       = (state_r == ST_FIN) && out_free;
  assign cur_alpha   = rd_data_r[7:0];

  assign op_sat  = (in_ch.opacity > OPACITY_MAX) ? OPACITY_MAX : in_ch.opacity;
  assign w_prod  = {28'd0, z_r} * {27'd0, W_RECIP};
  assign acc_sum = {2'd0, oa_r, 16'd0} + {1'b0, acc_prod_r} + ACC_ROUND;
  assign q       = div100(t_r);

  always_comb begin
    if (first_r) begin
      alpha_fin = q[7:0];
    end else if (cur_alpha == ALPHA_FULL) begin
      alpha_fin = cur_alpha;
    end else if (q > {2'd0, ALPHA_FULL}) begin
      alpha_fin = ALPHA_FULL;
    end else begin
      alpha_fin = q[7:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_WGT;
      ST_WGT:  state_nxt = ST_MIX;
      ST_MIX:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // store port: one read on accept, one write at the end of the item
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= store_mem[in_ch.pixel_index];
    end
    if (wr_en) begin
      store_mem[idx_r] <= {mix_red_r, mix_green_r, mix_blue_r, alpha_fin};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r   <= in_ch.pixel_index;
      first_r <= in_ch.first_layer;
      red_r   <= in_ch.red_in;
      green_r <= in_ch.green_in;
      blue_r  <= in_ch.blue_in;
      oa_r    <= 15'(op_sat * in_ch.alpha_in);
    end
    if (state_r == ST_RD) begin
      z_r <= {12'd0, oa_r} * Z_MUL + Z_BIAS;
    end
    if (state_r == ST_WGT) begin
      w_r <= {1'b0, oa_r, 1'b0} + {2'd0, w_prod[W_SHIFT+14:W_SHIFT]};
    end
    if (state_r == ST_MIX) begin
      if (first_r) begin
        mix_red_r   <= red_r;
        mix_green_r <= green_r;
        mix_blue_r  <= blue_r;
      end else begin
        mix_red_r   <= mix_channel(w_r, red_r, rd_data_r[31:24]);
        mix_green_r <= mix_channel(w_r, green_r, rd_data_r[23:16]);
        mix_blue_r  <= mix_channel(w_r, blue_r, rd_data_r[15:8]);
      end
      acc_prod_r <= {15'd0, W_ONE - w_r} * {17'd0, 15'(cur_alpha * 7'd100)};
    end
    if (state_r == ST_ACC) begin
      // acc_sum stays below 2^32
      t_r <= first_r ? (16'(oa_r) + COPY_ROUND) : acc_sum[31:16];
    end
    if (wr_en) begin
      out_idx_r   <= idx_r;
      out_red_r   <= mix_red_r;
      out_green_r <= mix_green_r;
      out_blue_r  <= mix_blue_r;
      out_alpha_r <= alpha_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.pixel_index_out = out_idx_r;
  assign out_ch.red_out         = out_red_r;
  assign out_ch.green_out       = out_green_r;
  assign out_ch.blue_out        = out_blue_r;
  assign out_ch.alpha_out       = out_alpha_r;

  `LOAC_ASSERT_NOW(a_wr_slot_free, clk, rst_n, wr_en, !out_valid_r || out_ch.ready,
                   "store write while output word still pending")
  `LOAC_ASSERT_NEXT(a_out_tracks_write, clk, rst_n, wr_en,
                    out_ch.valid && out_ch.pixel_index_out == $past(idx_r),
                    "output word does not match the written entry")
  `LOAC_ASSERT_NOW(a_weight_bound, clk, rst_n, state_r == ST_MIX, w_r <= W_ONE,
                   "blend weight above one")
  `LOAC_ASSERT_NEXT(a_full_alpha_kept, clk, rst_n,
                    wr_en && !first_r && cur_alpha == ALPHA_FULL,
                    out_ch.alpha_out == ALPHA_FULL,
                    "saturated composite alpha changed")

endmodule
`default_nettype wire
